// File: hdl/timed_relay_batch_sequencer_defines.svh
// Assertion macros used by the checker of this block.
`ifndef TIMED_RELAY_BATCH_SEQUENCER_DEFINES_SVH
`define TIMED_RELAY_BATCH_SEQUENCER_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define TRBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TRBS_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/trbs_pkg.sv
package trbs_pkg;

  // Phase timer width and the fixed widths of the register fields.
  localparam int TIME_W     = 20;
  localparam int CFG_TIME_W = 20;
  localparam int DEB_W      = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CMP_W      = (TIME_W > CFG_TIME_W) ? TIME_W : CFG_TIME_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [DEB_W-1:0]  DEB_MAX  = {DEB_W{1'b1}};

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAPER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARCH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIXING     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_OPEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PREP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_WAIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd7;

  // Register reset values.
  localparam logic [CFG_TIME_W-1:0] RST_PHASE_TIME = 20'd5000;
  localparam logic [CFG_TIME_W-1:0] RST_CLOSE_WAIT = 20'd3000;
  localparam logic [DEB_W-1:0]      RST_DEBOUNCE   = 16'd50;

  // Relay bits.
  localparam logic [4:0] R_NONE   = 5'b00000;
  localparam logic [4:0] R_MIXER  = 5'b00001;
  localparam logic [4:0] R_PAPER  = 5'b00010;
  localparam logic [4:0] R_STARCH = 5'b00100;
  localparam logic [4:0] R_WATER  = 5'b01000;
  localparam logic [4:0] R_DOOR   = 5'b10000;

  // Phase codes as seen on the result channel.
  localparam logic [3:0] PC_IDLE   = 4'd0;
  localparam logic [3:0] PC_PREP   = 4'd1;
  localparam logic [3:0] PC_PAPER  = 4'd2;
  localparam logic [3:0] PC_STARCH = 4'd3;
  localparam logic [3:0] PC_WATER  = 4'd4;
  localparam logic [3:0] PC_MIXING = 4'd5;
  localparam logic [3:0] PC_PROMPT = 4'd6;
  localparam logic [3:0] PC_DOOR   = 4'd7;
  localparam logic [3:0] PC_CLOSE  = 4'd8;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_PREP   = 9'b000000010,
    PH_PAPER  = 9'b000000100,
    PH_STARCH = 9'b000001000,
    PH_WATER  = 9'b000010000,
    PH_MIXING = 9'b000100000,
    PH_PROMPT = 9'b001000000,
    PH_DOOR   = 9'b010000000,
    PH_CLOSE  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] paper_time;
    logic [CFG_TIME_W-1:0] starch_time;
    logic [CFG_TIME_W-1:0] water_time;
    logic [CFG_TIME_W-1:0] mixing_time;
    logic [CFG_TIME_W-1:0] door_open_time;
    logic [CFG_TIME_W-1:0] prep_time;
    logic [CFG_TIME_W-1:0] close_wait_time;
    logic [DEB_W-1:0]      debounce_time;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic              run;
    logic [TIME_W-1:0] elapsed;
    logic              enter_prev;
    logic [DEB_W-1:0]  since_enter;
    logic [4:0]        relays;
  } state_t;

  typedef struct packed {
    logic       up;
    logic       enter;
    logic       down;
    logic       start;
  } tick_t;

  function automatic logic [3:0] phase_code(input phase_t p);
    logic [3:0] c;
    unique case (p)
      PH_IDLE:   c = PC_IDLE;
      PH_PREP:   c = PC_PREP;
      PH_PAPER:  c = PC_PAPER;
      PH_STARCH: c = PC_STARCH;
      PH_WATER:  c = PC_WATER;
      PH_MIXING: c = PC_MIXING;
      PH_PROMPT: c = PC_PROMPT;
      PH_DOOR:   c = PC_DOOR;
      PH_CLOSE:  c = PC_CLOSE;
      default:   c = PC_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/trbs_if.sv
interface trbs_in_if;
  logic valid;
  logic ready;
  logic up_level;
  logic enter_level;
  logic down_level;
  logic start_request;

  modport source (output valid, up_level, enter_level, down_level, start_request,
                  input ready);
  modport sink (input valid, up_level, enter_level, down_level, start_request,
                output ready);
endinterface

interface trbs_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] relay_drive;
  logic [3:0] phase;
  logic       running;
  logic       aborted;

  modport source (output valid, relay_drive, phase, running, aborted, input ready);
  modport sink (input valid, relay_drive, phase, running, aborted, output ready);
endinterface

// File: hdl/timed_relay_batch_sequencer.sv
// Timed relay batch sequencer.
// in_ch carries one millisecond tick per transfer: the raw Up, Enter and Down
// levels and the start request from the menu. out_ch returns exactly one
// result per tick: relay_drive (bit0 mixer .. bit4 door, active high), the
// phase code, running, and aborted for the tick on which all three buttons
// stopped a run. The cfg_ port writes one timing register per cycle while
// cfg_we is high; write only while no tick is in flight.
// Latency: the result of a tick is valid the cycle after its transfer. The
// whole update is one pass through the step logic into the state and result
// registers, so one tick is taken every cycle unless the receiver stalls.
// The result register lets the next tick in while a result waits: in_ch.ready
// is high whenever the result slot is empty or being taken in that cycle.
// If the receiver stalls, the result holds and in_ch.ready drops until it goes.
// Reset (rst_n low, synchronous) loads the default timings, returns to idle
// with all relays off, and empties the result slot.
module timed_relay_batch_sequencer
  import trbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  trbs_in_if.sink               in_ch,
  trbs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  state_t state_r;
  state_t state_nxt;
  tick_t  tick;
  logic   aborted_nxt;
  logic   accept;

  logic       out_valid_r;
  logic [4:0] relay_r;
  logic [3:0] phase_r;
  logic       running_r;
  logic       aborted_r;

  trbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign tick.up    = in_ch.up_level;
  assign tick.enter = in_ch.enter_level;
  assign tick.down  = in_ch.down_level;
  assign tick.start = in_ch.start_request;

  trbs_step u_step (
    .cur     (state_r),
    .tick    (tick),
    .cfg     (cfg),
    .nxt     (state_nxt),
    .aborted (aborted_nxt)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_IDLE;
      state_r.run         <= 1'b0;
      state_r.elapsed     <= '0;
      state_r.enter_prev  <= 1'b0;
      state_r.since_enter <= '0;
      state_r.relays      <= R_NONE;
      out_valid_r         <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load on every tick transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      relay_r   <= state_nxt.relays;
      phase_r   <= phase_code(state_nxt.phase);
      running_r <= state_nxt.run;
      aborted_r <= aborted_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.relay_drive = relay_r;
  assign out_ch.phase       = phase_r;
  assign out_ch.running     = running_r;
  assign out_ch.aborted     = aborted_r;

endmodule

// File: hdl/trbs_cfg.sv
module trbs_cfg
  import trbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.paper_time      <= RST_PHASE_TIME;
      cfg_r.starch_time     <= RST_PHASE_TIME;
      cfg_r.water_time      <= RST_PHASE_TIME;
      cfg_r.mixing_time     <= RST_PHASE_TIME;
      cfg_r.door_open_time  <= RST_PHASE_TIME;
      cfg_r.prep_time       <= RST_PHASE_TIME;
      cfg_r.close_wait_time <= RST_CLOSE_WAIT;
      cfg_r.debounce_time   <= RST_DEBOUNCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAPER:      cfg_r.paper_time      <= cfg_data[CFG_TIME_W-1:0];
        CFG_STARCH:     cfg_r.starch_time     <= cfg_data[CFG_TIME_W-1:0];
        CFG_WATER:      cfg_r.water_time      <= cfg_data[CFG_TIME_W-1:0];
        CFG_MIXING:     cfg_r.mixing_time     <= cfg_data[CFG_TIME_W-1:0];
        CFG_DOOR_OPEN:  cfg_r.door_open_time  <= cfg_data[CFG_TIME_W-1:0];
        CFG_PREP:       cfg_r.prep_time       <= cfg_data[CFG_TIME_W-1:0];
        CFG_CLOSE_WAIT: cfg_r.close_wait_time <= cfg_data[CFG_TIME_W-1:0];
        CFG_DEBOUNCE:   cfg_r.debounce_time   <= cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/trbs_step.sv
module trbs_step
  import trbs_pkg::*;
(
  input  state_t cur,
  input  tick_t  tick,
  input  cfg_t   cfg,
  output state_t nxt,
  output logic   aborted
);

  logic                  press;
  logic                  has_timer;
  logic [CFG_TIME_W-1:0] limit;
  phase_t                t_phase;
  logic [4:0]            t_relays;

  always_comb begin
    nxt       = cur;
    aborted   = 1'b0;
    press     = 1'b0;
    has_timer = 1'b0;
    limit     = '0;
    t_phase   = PH_IDLE;
    t_relays  = R_NONE;

    if (cur.since_enter != DEB_MAX) begin
      nxt.since_enter = cur.since_enter + 1'b1;
    end

    if (cur.run && tick.up && tick.enter && tick.down) begin
      // emergency stop: drop everything, keep the Enter history
      nxt.run     = 1'b0;
      nxt.phase   = PH_IDLE;
      nxt.relays  = R_NONE;
      nxt.elapsed = '0;
      aborted     = 1'b1;
    end else begin
      press = tick.enter && !cur.enter_prev && (nxt.since_enter > cfg.debounce_time);
      if (press) begin
        nxt.since_enter = '0;
        if (cur.run && cur.phase == PH_PROMPT) begin
          nxt.phase   = PH_DOOR;
          nxt.relays  = cur.relays | R_DOOR;
          nxt.elapsed = '0;
        end
      end
      nxt.enter_prev = tick.enter;

      if (tick.start && !cur.run) begin
        nxt.run     = 1'b1;
        nxt.phase   = PH_PREP;
        nxt.relays  = R_MIXER;
        nxt.elapsed = '0;
      end

      unique case (nxt.phase)
        PH_PREP: begin
          has_timer = 1'b1; limit = cfg.prep_time;
          t_phase = PH_PAPER; t_relays = R_MIXER | R_PAPER;
        end
        PH_PAPER: begin
          has_timer = 1'b1; limit = cfg.paper_time;
          t_phase = PH_STARCH; t_relays = R_MIXER | R_STARCH;
        end
        PH_STARCH: begin
          has_timer = 1'b1; limit = cfg.starch_time;
          t_phase = PH_WATER; t_relays = R_MIXER | R_WATER;
        end
        PH_WATER: begin
          has_timer = 1'b1; limit = cfg.water_time;
          t_phase = PH_MIXING; t_relays = R_MIXER;
        end
        PH_MIXING: begin
          has_timer = 1'b1; limit = cfg.mixing_time;
          t_phase = PH_PROMPT; t_relays = R_MIXER;
        end
        PH_DOOR: begin
          has_timer = 1'b1; limit = cfg.door_open_time;
          t_phase = PH_CLOSE; t_relays = nxt.relays & ~R_DOOR;
        end
        PH_CLOSE: begin
          has_timer = 1'b1; limit = cfg.close_wait_time;
          t_phase = PH_PROMPT; t_relays = nxt.relays;
        end
        default: ;
      endcase

      if (nxt.run && has_timer) begin
        if (CMP_W'(nxt.elapsed) >= CMP_W'(limit)) begin
          nxt.phase   = t_phase;
          nxt.relays  = t_relays;
          nxt.elapsed = '0;
        end else if (nxt.elapsed != TIME_MAX) begin
          nxt.elapsed = nxt.elapsed + 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/trbs_chk.sv
`include "timed_relay_batch_sequencer_defines.svh"

module trbs_chk
  import trbs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] relay_drive,
  input logic [3:0] phase,
  input logic       running,
  input logic       aborted
);

  `TRBS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  `TRBS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result dropped")

  `TRBS_ASSERT(a_tick_result, in_valid && in_ready |=> out_valid, "tick transfer gave no result")

  `TRBS_ASSERT(a_idle_off, out_valid |-> (running || (phase == PC_IDLE && relay_drive == R_NONE)) && (!aborted || !running), "stopped block shows a phase or relay")

  `TRBS_ASSERT(a_door_phase, out_valid |-> (relay_drive[4] == (phase == PC_DOOR)) && (!running || relay_drive[0]), "door relay or mixer out of step with phase")

endmodule

bind timed_relay_batch_sequencer trbs_chk u_trbs_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .relay_drive (out_ch.relay_drive),
  .phase       (out_ch.phase),
  .running     (out_ch.running),
  .aborted     (out_ch.aborted)
);
